// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ilsp_pkg.sv
`default_nettype none

package ilsp_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int GYRO_W     = 16;
    localparam int WEIGHT_W   = 16;
    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 15;
    localparam int ERR_W      = 16;
    localparam int STEER_W    = 16;
    localparam int DEN_W      = 14;
    localparam int NUM_W      = 31;
    localparam int MAG_W      = 30;
    localparam int QUO_W      = 16;
    localparam int OP_B_W     = 32;
    localparam int PROD_W     = GAIN_W + OP_B_W;
    localparam int ACC_W      = 64;

    // Port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    // Sensor sample ceiling
    localparam logic [SAMPLE_W-1:0] SAMPLE_CEILING = 12'd4000;

    // Saturation bounds of the Q4.12 error
    localparam logic [ERR_W-1:0] ERR_POS_MAX = 16'h7FFF;
    localparam logic [ERR_W-1:0] ERR_NEG_MAX = 16'h8000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_WEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd6;

    // Register reset values
    localparam logic [WEIGHT_W-1:0] OUTER_WEIGHT_RST = 16'd6144;
    localparam logic [WEIGHT_W-1:0] INNER_WEIGHT_RST = 16'd4096;
    localparam logic [LIMIT_W-1:0]  OUTPUT_LIMIT_RST = 15'd450;

    // Multiplier step codes: operand selection and accumulation target
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_OUTER = 3'd0;
    localparam logic [STEP_W-1:0] STEP_INNER = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SQ    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_PROP  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_SQG   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DER   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_GYRO  = 3'd6;

    // Divider iterations, one quotient bit each
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              mul;
        logic              acc;
        logic              mag;
        logic              setup;
        logic              div;
        logic              err;
        logic              rnd;
        logic              out;
        logic [STEP_W-1:0] step;
    } ilsp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
    } ilsp_sts_t;

endpackage

`default_nettype wire

// File: sv/ilsp_ctrl.sv
`default_nettype none

module ilsp_ctrl import ilsp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ilsp_sts_t sts,
    output ilsp_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_ACC   = 4'd2;
    localparam logic [3:0] ST_MAG   = 4'd3;
    localparam logic [3:0] ST_SETUP = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_ERR   = 4'd6;
    localparam logic [3:0] ST_RND   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // Sequence: two weight products, magnitude, divide, error, five products, round, output
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    step_next  = STEP_OUTER;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (step_reg == STEP_INNER) begin
                    state_next = ST_MAG;
                end else if (step_reg == STEP_GYRO) begin
                    state_next = ST_RND;
                end else begin
                    step_next  = step_reg + 3'd1;
                    state_next = ST_MUL;
                end
            end
            ST_MAG: begin
                cmd.mag    = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div  = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                cmd.err    = 1'b1;
                step_next  = STEP_SQ;
                state_next = ST_MUL;
            end
            ST_RND: begin
                cmd.rnd    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!sts.out_busy) begin
                    cmd.out    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_OUTER;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/ilsp_dp.sv
`default_nettype none

module ilsp_dp import ilsp_pkg::*; #(
    parameter logic [SAMPLE_W-1:0] SAMPLE_CEIL = SAMPLE_CEILING
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  ilsp_cmd_t             cmd,
    output ilsp_sts_t             sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic [SAMPLE_W-1:0] v);
        return (v > SAMPLE_CEIL) ? SAMPLE_CEIL : v;
    endfunction

    // Configuration registers
    logic        [WEIGHT_W-1:0] outer_w_reg, inner_w_reg;
    logic signed [GAIN_W-1:0]   prop_g_reg, square_g_reg, deriv_g_reg, gyro_g_reg;
    logic        [LIMIT_W-1:0]  limit_reg;

    // Item registers
    logic        [SAMPLE_W-1:0] ol_reg, il_reg, ir_reg, or_reg;
    logic        [GYRO_W-1:0]   gyro_reg;
    logic        [DEN_W-1:0]    den_reg;
    logic        [NUM_W-1:0]    num_reg;
    logic        [MAG_W-1:0]    mag_reg;
    logic                       ovf_reg;
    logic        [DEN_W-1:0]    rem_reg;
    logic        [QUO_W-1:0]    dvd_reg;
    logic        [ERR_W-1:0]    e_reg;
    logic        [OP_B_W-1:0]   sq_reg;
    logic        [PROD_W-1:0]   prod_reg;
    logic        [ACC_W-1:0]    acc_reg;
    logic        [ACC_W-1:0]    absm_reg;
    logic                       out_neg_reg;

    // Control-side state and output registers
    logic                       m_tvalid_reg;
    logic        [ERR_W-1:0]    last_reg;
    logic        [STEER_W-1:0]  steer_reg;
    logic        [ERR_W-1:0]    err_out_reg;
    logic                       clamped_reg;
    logic                       zero_reg;

    // Load: clamp samples and form the denominator
    logic        [SAMPLE_W-1:0] ol_c, il_c, ir_c, or_c;
    logic signed [SAMPLE_W:0]   in_diff_c;
    logic        [SAMPLE_W:0]   in_abs_c;
    logic        [DEN_W-1:0]    den_c;

    always_comb begin
        ol_c      = clamp_sample(s_tdata[11:0]);
        il_c      = clamp_sample(s_tdata[23:12]);
        ir_c      = clamp_sample(s_tdata[35:24]);
        or_c      = clamp_sample(s_tdata[47:36]);
        in_diff_c = $signed({1'b0, il_c}) - $signed({1'b0, ir_c});
        in_abs_c  = in_diff_c[SAMPLE_W] ? 13'(-in_diff_c) : in_diff_c;
        den_c     = DEN_W'(ol_c) + DEN_W'(or_c) + DEN_W'(in_abs_c[SAMPLE_W-1:0]);
    end

    // Shared multiplier operand selection
    logic signed [SAMPLE_W:0]   outer_d, inner_d;
    logic signed [ERR_W:0]      e_ext, e_abs, e_diff;
    logic signed [GAIN_W-1:0]   op_a;
    logic signed [OP_B_W-1:0]   op_b;
    logic signed [PROD_W-1:0]   prod_c;

    always_comb begin
        outer_d = $signed({1'b0, ol_reg}) - $signed({1'b0, or_reg});
        inner_d = $signed({1'b0, il_reg}) - $signed({1'b0, ir_reg});
        e_ext   = $signed({e_reg[ERR_W-1], e_reg});
        e_abs   = e_ext[ERR_W] ? -e_ext : e_ext;
        e_diff  = e_ext - $signed({last_reg[ERR_W-1], last_reg});
        case (cmd.step)
            STEP_OUTER: begin
                op_a = {8'd0, outer_w_reg};
                op_b = {{19{outer_d[SAMPLE_W]}}, outer_d};
            end
            STEP_INNER: begin
                op_a = {8'd0, inner_w_reg};
                op_b = {{18{inner_d[SAMPLE_W]}}, inner_d, 1'b0};
            end
            STEP_SQ: begin
                op_a = {7'd0, e_abs};
                op_b = {{16{e_reg[ERR_W-1]}}, e_reg};
            end
            STEP_PROP: begin
                op_a = prop_g_reg;
                op_b = {{16{e_reg[ERR_W-1]}}, e_reg};
            end
            STEP_SQG: begin
                op_a = square_g_reg;
                op_b = sq_reg;
            end
            STEP_DER: begin
                op_a = deriv_g_reg;
                op_b = {{15{e_diff[ERR_W]}}, e_diff};
            end
            STEP_GYRO: begin
                op_a = gyro_g_reg;
                op_b = {{16{gyro_reg[GYRO_W-1]}}, gyro_reg};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_c = op_a * op_b;
    end

    // Accumulate term: product scaled into Q32
    logic [ACC_W-1:0] prod_ext, term_c;

    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        case (cmd.step)
            STEP_SQG:  term_c = prod_ext << 1;
            STEP_GYRO: term_c = prod_ext << 24;
            default:   term_c = prod_ext << 12;
        endcase
    end

    // Divider step and error saturation
    logic [NUM_W-1:0] num_abs;
    logic [DEN_W:0]   trial;
    logic             trial_ge;
    logic [DEN_W:0]   trial_sub;
    logic             zero_c;
    logic [ERR_W-1:0] e_c;

    always_comb begin
        num_abs   = num_reg[NUM_W-1] ? (31'd0 - num_reg) : num_reg;
        trial     = {rem_reg, dvd_reg[QUO_W-1]};
        trial_ge  = trial >= {1'b0, den_reg};
        trial_sub = trial - {1'b0, den_reg};
        zero_c    = (den_reg == '0);
        if (zero_c) begin
            e_c = '0;
        end else if (num_reg[NUM_W-1]) begin
            e_c = (ovf_reg || dvd_reg > ERR_NEG_MAX) ? ERR_NEG_MAX : 16'(16'd0 - dvd_reg);
        end else begin
            e_c = (ovf_reg || dvd_reg > ERR_POS_MAX) ? ERR_POS_MAX : dvd_reg;
        end
    end

    // Round half away from zero, then clamp to the limit
    logic [ACC_W-1:0]   rsum;
    logic [31:0]        r_c;
    logic               clamped_c;
    logic [LIMIT_W-1:0] smag_c;
    logic [STEER_W-1:0] steer_c;

    always_comb begin
        rsum      = absm_reg + 64'h0000_0000_8000_0000;
        r_c       = rsum[63:32];
        clamped_c = r_c > {17'd0, limit_reg};
        smag_c    = clamped_c ? limit_reg : r_c[LIMIT_W-1:0];
        steer_c   = out_neg_reg ? 16'(16'd0 - {1'b0, smag_c}) : {1'b0, smag_c};
    end

    // Configuration writes, last error and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outer_w_reg  <= OUTER_WEIGHT_RST;
            inner_w_reg  <= INNER_WEIGHT_RST;
            prop_g_reg   <= '0;
            square_g_reg <= '0;
            deriv_g_reg  <= '0;
            gyro_g_reg   <= '0;
            limit_reg    <= OUTPUT_LIMIT_RST;
            last_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_OUTER_WEIGHT: outer_w_reg  <= cfg_wdata[WEIGHT_W-1:0];
                    REG_INNER_WEIGHT: inner_w_reg  <= cfg_wdata[WEIGHT_W-1:0];
                    REG_PROP_GAIN:    prop_g_reg   <= cfg_wdata;
                    REG_SQUARE_GAIN:  square_g_reg <= cfg_wdata;
                    REG_DERIV_GAIN:   deriv_g_reg  <= cfg_wdata;
                    REG_GYRO_GAIN:    gyro_g_reg   <= cfg_wdata;
                    REG_OUTPUT_LIMIT: limit_reg    <= cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.out) begin
                last_reg     <= e_reg;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ol_reg   <= ol_c;
            il_reg   <= il_c;
            ir_reg   <= ir_c;
            or_reg   <= or_c;
            gyro_reg <= s_tdata[63:48];
            den_reg  <= den_c;
        end
        if (cmd.mul) begin
            prod_reg <= prod_c;
        end
        if (cmd.acc) begin
            case (cmd.step)
                STEP_OUTER: num_reg <= prod_reg[NUM_W-1:0];
                STEP_INNER: num_reg <= num_reg + prod_reg[NUM_W-1:0];
                STEP_SQ:    sq_reg  <= prod_reg[OP_B_W-1:0];
                default:    acc_reg <= acc_reg + term_c;
            endcase
        end
        if (cmd.mag) begin
            mag_reg <= num_abs[MAG_W-1:0];
        end
        // A quotient that does not fit in 16 bits saturates the error
        if (cmd.setup) begin
            ovf_reg <= mag_reg[MAG_W-1:QUO_W] >= den_reg;
            rem_reg <= mag_reg[MAG_W-1:QUO_W];
            dvd_reg <= mag_reg[QUO_W-1:0];
        end
        if (cmd.div) begin
            rem_reg <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            dvd_reg <= {dvd_reg[QUO_W-2:0], trial_ge};
        end
        if (cmd.err) begin
            e_reg   <= e_c;
            acc_reg <= '0;
        end
        if (cmd.rnd) begin
            absm_reg    <= acc_reg[ACC_W-1] ? (64'd0 - acc_reg) : acc_reg;
            out_neg_reg <= acc_reg[ACC_W-1];
        end
        if (cmd.out) begin
            steer_reg   <= steer_c;
            err_out_reg <= e_reg;
            clamped_reg <= clamped_c;
            zero_reg    <= zero_c;
        end
    end

    assign sts.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = {err_out_reg, steer_reg};
    assign m_tuser      = {zero_reg, clamped_reg};

endmodule

`default_nettype wire

// File: sv/inductive_line_steering_pd.sv
// One item at a time: s_tready stays low from the input transfer until the result is loaded,
// which waits on the 16-step restoring divider and the seven passes through the single
// shared 24x32 multiplier; a held output stalls the result load.
// Reset: synchronous, active-low aresetn; restores register defaults, clears the
// previous error and drops m_tvalid.
`default_nettype none
`include "assert_macros.svh"

module inductive_line_steering_pd import ilsp_pkg::*; #(
    parameter logic [SAMPLE_W-1:0] SAMPLE_CEIL = SAMPLE_CEILING
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Sensor input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // outer_left[11:0], inner_left[23:12], inner_right[35:24], outer_right[47:36],
    // gyro_rate[63:48]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Steering result
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // steer_out[15:0], error_value[31:16]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // was_clamped[0], zero_sum[1]
    output logic [OUT_USER_W-1:0] m_tuser
);

    ilsp_cmd_t cmd;
    ilsp_sts_t sts;

    ilsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ilsp_dp #(
        .SAMPLE_CEIL (SAMPLE_CEIL)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // One item at a time: no new transfer right after one is taken
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "input ready right after accept")
    // Never overwrite a result that is still waiting
    `ASSERT_ALWAYS(a_no_overwrite, aclk, aresetn, !(cmd.out && m_tvalid && !m_tready),
        "pending result overwritten")
    // Output valid rises only from a result load
    `ASSERT_ALWAYS(a_valid_source, aclk, aresetn, !$rose(m_tvalid) || $past(cmd.out),
        "output valid without result load")
    // Zero denominator forces a zero error
    `ASSERT_ALWAYS(a_zero_err, aclk, aresetn,
        !(m_tvalid && m_tuser[1]) || (m_tdata[31:16] == 16'd0), "zero sum with nonzero error")

endmodule

`default_nettype wire

// File: verif/ilsp_steer_checker.sv
`timescale 1ns / 100ps

module ilsp_steer_checker import ilsp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // outer_left[11:0], inner_left[23:12], inner_right[35:24], outer_right[47:36],
    // gyro_rate[63:48]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // steer_out[15:0], error_value[31:16]
    input  logic [OUT_DATA_W-1:0] m_tdata,
    // was_clamped[0], zero_sum[1]
    input  logic [OUT_USER_W-1:0] m_tuser,
    output int                    mismatch_cnt,
    output int                    pending_cnt
);

    typedef struct packed {
        logic signed [STEER_W-1:0] steer;
        logic signed [ERR_W-1:0]   err;
        logic                      clamped;
        logic                      zero_sum;
    } steer_result_t;

    // Shadow copy of the register file and the previous error
    logic [WEIGHT_W-1:0]      outer_w;
    logic [WEIGHT_W-1:0]      inner_w;
    logic signed [GAIN_W-1:0] prop_g;
    logic signed [GAIN_W-1:0] sq_g;
    logic signed [GAIN_W-1:0] der_g;
    logic signed [GAIN_W-1:0] gyro_g;
    logic [LIMIT_W-1:0]       steer_lim;
    logic signed [ERR_W-1:0]  prev_err;

    steer_result_t steer_due_q[$];
    int            fail_cnt = 0;

    function automatic longint clip_sample(input logic [SAMPLE_W-1:0] v);
        return (v > SAMPLE_CEILING) ? longint'(SAMPLE_CEILING) : longint'(v);
    endfunction

    // Difference-over-sum error, then the weighted correction terms summed in Q32
    function automatic steer_result_t predict_steer(input logic [IN_DATA_W-1:0] d);
        longint        ol, il, ir, orr, gyro, inner, den, num, quo, err, sum, mag, rnd, lim;
        steer_result_t res;
        ol    = clip_sample(d[11:0]);
        il    = clip_sample(d[23:12]);
        ir    = clip_sample(d[35:24]);
        orr   = clip_sample(d[47:36]);
        gyro  = longint'($signed(d[63:48]));
        inner = il - ir;
        den   = ol + orr + ((inner < 0) ? -inner : inner);
        num   = longint'(outer_w) * (ol - orr) + longint'(inner_w) * 2 * inner;
        err   = 0;
        if (den != 0) begin
            // truncate toward zero, then saturate to Q4.12
            quo = ((num < 0) ? -num : num) / den;
            if (num < 0) begin
                err = (quo > 32768) ? -32768 : -quo;
            end else begin
                err = (quo > 32767) ? 32767 : quo;
            end
        end
        sum = longint'(prop_g) * err * 4096
            + longint'(sq_g) * (err * ((err < 0) ? -err : err)) * 2
            + longint'(der_g) * (err - longint'(prev_err)) * 4096
            + longint'(gyro_g) * gyro * 16777216;
        // round half away from zero
        mag = (sum < 0) ? -sum : sum;
        rnd = (mag + 64'sh8000_0000) >>> 32;
        rnd = (sum < 0) ? -rnd : rnd;
        lim = longint'(steer_lim);
        res.clamped = 1'b0;
        if (rnd > lim) begin
            rnd         = lim;
            res.clamped = 1'b1;
        end else if (rnd < -lim) begin
            rnd         = -lim;
            res.clamped = 1'b1;
        end
        res.steer    = rnd[STEER_W-1:0];
        res.err      = err[ERR_W-1:0];
        res.zero_sum = (den == 0);
        return res;
    endfunction

    task automatic report_miss(input string what);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    // Track config writes, predict on each input transfer, check each result transfer
    always @(posedge aclk) begin : track
        steer_result_t got;
        steer_result_t want;
        if (!aresetn) begin
            outer_w   = OUTER_WEIGHT_RST;
            inner_w   = INNER_WEIGHT_RST;
            prop_g    = '0;
            sq_g      = '0;
            der_g     = '0;
            gyro_g    = '0;
            steer_lim = OUTPUT_LIMIT_RST;
            prev_err  = '0;
            steer_due_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_OUTER_WEIGHT: outer_w   = cfg_wdata[WEIGHT_W-1:0];
                    REG_INNER_WEIGHT: inner_w   = cfg_wdata[WEIGHT_W-1:0];
                    REG_PROP_GAIN:    prop_g    = cfg_wdata;
                    REG_SQUARE_GAIN:  sq_g      = cfg_wdata;
                    REG_DERIV_GAIN:   der_g     = cfg_wdata;
                    REG_GYRO_GAIN:    gyro_g    = cfg_wdata;
                    REG_OUTPUT_LIMIT: steer_lim = cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = predict_steer(s_tdata);
                steer_due_q.push_back(want);
                prev_err = want.err;
            end
            if (m_tvalid && m_tready) begin
                got.steer    = m_tdata[15:0];
                got.err      = m_tdata[31:16];
                got.clamped  = m_tuser[0];
                got.zero_sum = m_tuser[1];
                if (steer_due_q.size() == 0) begin
                    report_miss($sformatf("unexpected result steer=%0d err=%0d clamped=%0b zs=%0b",
                        got.steer, got.err, got.clamped, got.zero_sum));
                end else begin
                    want = steer_due_q.pop_front();
                    if (got.steer !== want.steer || got.err !== want.err ||
                        got.clamped !== want.clamped || got.zero_sum !== want.zero_sum) begin
                        report_miss($sformatf(
                            "mismatch: expected steer=%0d err=%0d clamped=%0b zs=%0b, %s",
                            want.steer, want.err, want.clamped, want.zero_sum,
                            $sformatf("got steer=%0d err=%0d clamped=%0b zs=%0b",
                                got.steer, got.err, got.clamped, got.zero_sum)));
                    end
                end
            end
        end
        mismatch_cnt <= fail_cnt;
        pending_cnt  <= steer_due_q.size();
    end

endmodule

// File: verif/inductive_line_steering_pd_tb.sv
`timescale 1ns / 100ps

module inductive_line_steering_pd_tb;
    import ilsp_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASES       = 6;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // outer_left[11:0], inner_left[23:12], inner_right[35:24], outer_right[47:36],
    // gyro_rate[63:48]
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // steer_out[15:0], error_value[31:16]
    logic [OUT_DATA_W-1:0] m_tdata;
    // was_clamped[0], zero_sum[1]
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  idle_on   = 1'b1;
    int                    mismatch_cnt;
    int                    pending_cnt;
    int                    cycle_cnt = 0;

    inductive_line_steering_pd dut (.*);

    ilsp_steer_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel at random while idling is on
    always @(posedge aclk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 13);
    end

    // Hard stop on a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_sample(
        input logic [SAMPLE_W-1:0] ol, input logic [SAMPLE_W-1:0] il,
        input logic [SAMPLE_W-1:0] ir, input logic [SAMPLE_W-1:0] orr,
        input logic [GYRO_W-1:0] gyro);
        return {gyro, orr, ir, il, ol};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] v [4];
        logic [GYRO_W-1:0]   g;
        int                  shape;
        int                  center;
        shape  = $urandom_range(9);
        center = $urandom_range(0, 4095);
        foreach (v[i]) begin
            case (shape)
                0, 1, 2: v[i] = SAMPLE_W'($urandom);
                3:       v[i] = SAMPLE_W'($urandom_range(3900, 4095));
                4:       v[i] = SAMPLE_W'($urandom_range(0, 1));
                5:       v[i] = SAMPLE_W'($urandom_range(0, 20));
                // line near the sensors: readings of similar size
                default: v[i] = SAMPLE_W'($urandom_range(center / 2, center));
            endcase
        end
        case ($urandom_range(3))
            1:       g = GYRO_W'($urandom_range(0, 512) - 256);
            2:       g = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: g = GYRO_W'($urandom);
        endcase
        return pack_sample(v[0], v[1], v[2], v[3], g);
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(4))
            0:       return WEIGHT_W'($urandom);
            1:       return WEIGHT_W'($urandom_range(2048, 8192));
            2:       return 16'hFFFF;
            3:       return '0;
            default: return WEIGHT_W'($urandom_range(4096, 6144));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(4))
            0:       return GAIN_W'($urandom);
            1:       return GAIN_W'($urandom_range(0, 8191) - 4096);
            2:       return GAIN_W'($urandom_range(0, 131071) - 65536);
            3:       return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            default: return '0;
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] random_limit();
        case ($urandom_range(3))
            0:       return LIMIT_W'($urandom);
            1:       return '0;
            2:       return 15'h7FFF;
            default: return LIMIT_W'($urandom_range(50, 2000));
        endcase
    endfunction

    // Drop valid and hold until every expected result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_cnt != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
    endtask

    // Write the full register set while idle; upper bits of the weight and limit data carry junk
    task automatic load_settings(
        input logic [WEIGHT_W-1:0] ow, input logic [WEIGHT_W-1:0] iw,
        input logic [GAIN_W-1:0] pg, input logic [GAIN_W-1:0] sg,
        input logic [GAIN_W-1:0] dg, input logic [GAIN_W-1:0] gg,
        input logic [LIMIT_W-1:0] lim);
        drain_results();
        cfg_write(REG_OUTER_WEIGHT, {8'($urandom), ow});
        cfg_write(REG_INNER_WEIGHT, {8'($urandom), iw});
        cfg_write(REG_PROP_GAIN, pg);
        cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_write(REG_SQUARE_GAIN, sg);
        cfg_write(REG_DERIV_GAIN, dg);
        cfg_write(REG_GYRO_GAIN, gg);
        cfg_write(REG_OUTPUT_LIMIT, {9'($urandom), lim});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Present one item, with an occasional random gap while idling is on, and hold until the transfer
    task automatic send_sample(input logic [IN_DATA_W-1:0] d);
        if (idle_on && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin : stimulus
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Nominal weights, moderate gains: zero sum, ceiling, gyro extremes, each sensor alone
        load_settings(16'd6144, 16'd4096, 24'd25600, 24'd5120, 24'd2560, 24'd16, 15'd450);
        send_sample(pack_sample(12'd0, 12'd0, 12'd0, 12'd0, 16'h0000));
        send_sample(pack_sample(12'd0, 12'd0, 12'd0, 12'd0, 16'h7FFF));
        send_sample(pack_sample(12'd0, 12'd0, 12'd0, 12'd0, 16'h8000));
        send_sample(pack_sample(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'h0000));
        send_sample(pack_sample(12'hFFF, 12'd0, 12'd0, 12'd0, 16'h0000));
        send_sample(pack_sample(12'd4000, 12'd0, 12'd0, 12'd0, 16'h0000));
        send_sample(pack_sample(12'd4001, 12'd0, 12'd0, 12'd0, 16'h0000));
        send_sample(pack_sample(12'd0, 12'd0, 12'd0, 12'hFFF, 16'h0000));
        send_sample(pack_sample(12'd0, 12'hFFF, 12'd0, 12'd0, 16'h0000));
        send_sample(pack_sample(12'd0, 12'd0, 12'hFFF, 12'd0, 16'h0000));
        send_sample(pack_sample(12'd1, 12'd0, 12'd0, 12'd0, 16'h0001));
        send_sample(pack_sample(12'd100, 12'd3000, 12'd2900, 12'd120, 16'hFF38));

        // Largest weights: error saturates both ways, all gains at their extremes
        load_settings(16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                      15'h7FFF);
        send_sample(pack_sample(12'd4000, 12'd0, 12'd0, 12'd0, 16'h0000));
        send_sample(pack_sample(12'd0, 12'd0, 12'd0, 12'd4000, 16'h0000));
        send_sample(pack_sample(12'd0, 12'd4000, 12'd0, 12'd0, 16'h7FFF));
        send_sample(pack_sample(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'h7FFF));
        send_sample(pack_sample(12'd0, 12'd0, 12'd0, 12'd0, 16'h8000));

        // Zero limit, small gyro gain: rounding at half and below
        load_settings(16'd0, 16'd4096, 24'd256, 24'd0, 24'd0, 24'd1, 15'd0);
        send_sample(pack_sample(12'd0, 12'd0, 12'd0, 12'd0, 16'h0000));
        send_sample(pack_sample(12'd0, 12'd0, 12'd0, 12'd0, 16'd127));
        send_sample(pack_sample(12'd0, 12'd0, 12'd0, 12'd0, 16'd128));
        send_sample(pack_sample(12'd0, 12'd0, 12'd0, 12'd0, 16'hFF80));
        send_sample(pack_sample(12'd0, 12'd10, 12'd0, 12'd0, 16'd200));

        // Random phases; the fourth runs with no idling on either side
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: load_settings(16'd6144, 16'd4096, 24'd10240, 24'd3840, 24'd15360,
                                 24'hFFFFF0, 15'd450);
                1: load_settings(16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                 24'h7FFFFF, 15'h7FFF);
                2: load_settings(16'd0, 16'hFFFF, 24'h800000, 24'h800000, 24'h800000,
                                 24'h800000, 15'd0);
                default: load_settings(random_weight(), random_weight(), random_gain(),
                                       random_gain(), random_gain(), random_gain(),
                                       random_limit());
            endcase
            idle_on <= (p != 3);
            repeat (RANDOM_ITEMS / PHASES) send_sample(random_sample());
        end

        drain_results();
        if (mismatch_cnt == 0 && pending_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
